// ----- rtl/core/coap_option_encoder_top_assert.svh -----
// Assertion macros shared by the option encoder queue and back end.
`ifndef COAP_OPTION_ENCODER_TOP_ASSERT_SVH
`define COAP_OPTION_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CAE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CAE_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define CAE_ASSERT(lbl, clk, rst_n, prop, msg)
`define CAE_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)
`endif
`endif

// ----- rtl/core/coap_enc_pkg.sv -----
// Types, constants and field encoder for the option encoder.
`timescale 1ns / 1ps
`default_nettype none
package coap_enc_pkg;

    localparam logic       REQ_OPTION   = 1'b0;
    localparam logic       REQ_VALUE    = 1'b1;
    localparam logic [15:0] EXT1_BASE   = 16'd13;
    localparam logic [15:0] EXT2_BASE   = 16'd269;
    localparam logic [3:0] NIB_EXT1     = 4'd13;
    localparam logic [3:0] NIB_EXT2     = 4'd14;
    localparam int         MAX_BYTES    = 5;
    localparam int         CNT_W        = 3;

    typedef struct packed {
        logic [3:0] nib;
        logic [1:0] n_ext;
        logic [7:0] ext0;
        logic [7:0] ext1;
    } field_enc_t;

    // One serialized item: up to five bytes, byte 0 sent first.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } entry_t;

    function automatic field_enc_t enc_field(input logic [15:0] v);
        field_enc_t r;
        logic [15:0] e;
        begin
            r = '0;
            e = v - EXT2_BASE;
            if (v >= EXT2_BASE)
            begin
                r.nib   = NIB_EXT2;
                r.n_ext = 2'd2;
                r.ext0  = e[15:8];
                r.ext1  = e[7:0];
            end
            else if (v >= EXT1_BASE)
            begin
                r.nib   = NIB_EXT1;
                r.n_ext = 2'd1;
                r.ext0  = 8'(v - EXT1_BASE);
            end
            else
            begin
                r.nib = v[3:0];
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/coap_enc_front.sv -----
// Front end: accepts words, forms the delta and packs the encoded bytes.
`timescale 1ns / 1ps
`default_nettype none
module coap_enc_front
    import coap_enc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        req_type,
    input  wire logic        first_option,
    input  wire logic [15:0] option_number,
    input  wire logic [15:0] value_length,
    input  wire logic [7:0]  value_byte,
    output entry_t           entry
);

    logic [15:0] prev_number_reg;
    logic [15:0] prev_number_next;
    logic [15:0] delta;
    field_enc_t  denc;
    field_enc_t  lenc;
    logic [7:0]  hdr;

    always_comb
    begin
        delta = first_option ? option_number : (option_number - prev_number_reg);
        denc  = enc_field(delta);
        lenc  = enc_field(value_length);
        hdr   = {denc.nib, lenc.nib};
        entry = '0;
        if (req_type == REQ_VALUE)
        begin
            entry.bytes[0] = value_byte;
            entry.count    = CNT_W'(1);
        end
        else
        begin
            entry.bytes[0] = hdr;
            // Length extension bytes follow whatever the delta extension used.
            unique case (denc.n_ext)
                2'd0:
                begin
                    entry.bytes[1] = lenc.ext0;
                    entry.bytes[2] = lenc.ext1;
                end
                2'd1:
                begin
                    entry.bytes[1] = denc.ext0;
                    entry.bytes[2] = lenc.ext0;
                    entry.bytes[3] = lenc.ext1;
                end
                default:
                begin
                    entry.bytes[1] = denc.ext0;
                    entry.bytes[2] = denc.ext1;
                    entry.bytes[3] = lenc.ext0;
                    entry.bytes[4] = lenc.ext1;
                end
            endcase
            entry.count = CNT_W'(1) + CNT_W'(denc.n_ext) + CNT_W'(lenc.n_ext);
        end
    end

    always_comb
    begin
        prev_number_next = prev_number_reg;
        if (accept && req_type == REQ_OPTION)
        begin
            prev_number_next = option_number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_number_reg <= '0;
        end
        else
        begin
            prev_number_reg <= prev_number_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/coap_enc_fifo.sv -----
// Short queue of packed entries between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "coap_option_encoder_top_assert.svh"
module coap_enc_fifo
    import coap_enc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_data,
    output logic        full,
    input  wire logic   pop,
    output logic        not_empty,
    output entry_t      pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t          mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `CAE_ASSERT(a_count_bound, clk, rst_n, count_reg <= FULL_CNT, "queue count overflow")
    `CAE_ASSERT(a_pop_nonempty, clk, rst_n, pop |-> not_empty, "pop from empty queue")
    `CAE_ASSERT(a_push_room, clk, rst_n, push |-> !full, "push into full queue")
    `CAE_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop,
        count_reg == CW'($past(count_reg) + CW'(1)), "queue count did not advance")

endmodule
`default_nettype wire

// ----- rtl/core/coap_enc_back.sv -----
// Back end: sends the bytes of an entry one per cycle unless stalled and marks the last one.
`timescale 1ns / 1ps
`default_nettype none
`include "coap_option_encoder_top_assert.svh"
module coap_enc_back
    import coap_enc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire entry_t      q_data,
    output logic             q_pop,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [7:0]       out_byte,
    output logic             last_byte
);

    entry_t           cur_reg;
    entry_t           cur_next;
    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             sent;
    logic             take;

    assign rsp_valid = busy_reg;
    assign last_byte = (idx_reg == cur_reg.count - CNT_W'(1));
    assign sent      = busy_reg && !rsp_stall;
    // A new entry loads when idle or as the final byte of the current one leaves.
    assign take      = !busy_reg || (sent && last_byte);
    assign q_pop     = take && q_valid;

    always_comb
    begin
        unique case (idx_reg)
            3'd0:    out_byte = cur_reg.bytes[0];
            3'd1:    out_byte = cur_reg.bytes[1];
            3'd2:    out_byte = cur_reg.bytes[2];
            3'd3:    out_byte = cur_reg.bytes[3];
            default: out_byte = cur_reg.bytes[4];
        endcase
    end

    always_comb
    begin
        cur_next  = cur_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take)
        begin
            busy_next = q_valid;
            idx_next  = '0;
            if (q_valid)
            begin
                cur_next = q_data;
            end
        end
        else if (sent)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    `CAE_ASSERT(a_count_range, clk, rst_n,
        busy_reg |-> (cur_reg.count != '0 && cur_reg.count <= CNT_W'(MAX_BYTES)),
        "entry byte count out of range")
    `CAE_ASSERT(a_idx_range, clk, rst_n, busy_reg |-> idx_reg < cur_reg.count,
        "byte index past entry end")
    `CAE_ASSERT_NEXT(a_stall_hold, clk, rst_n, busy_reg && rsp_stall,
        busy_reg && idx_reg == $past(idx_reg), "byte index moved while stalled")

endmodule
`default_nettype wire

// ----- rtl/core/coap_option_encoder_top.sv -----
// Top level of the option delta and length encoder.
//
//  Channel | Handshake           | Words
//  request | req_valid/req_stall | req_type, first_option, option_number, value_length,
//          |                     | value_byte
//  result  | rsp_valid/rsp_stall | out_byte, last_byte
//
// The front end encodes an item in the cycle it is accepted and writes it to the queue.
// The back end sends one byte per cycle while rsp_stall is low; an option start is one
// to five bytes and a value byte one byte, and the serializer's byte counter steps them.
// Requests stall only while the queue is full; result stalls hold the current byte.
// Reset clears the previous option number, the queue and the serializer.
`timescale 1ns / 1ps
`default_nettype none
module coap_option_encoder_top
    import coap_enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic        req_type,
    input  wire logic        first_option,
    input  wire logic [15:0] option_number,
    input  wire logic [15:0] value_length,
    input  wire logic [7:0]  value_byte,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [7:0]       out_byte,
    output logic             last_byte
);

    entry_t enc_entry;
    entry_t q_data;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    logic   accept;

    assign req_stall = q_full;
    assign accept    = req_valid && !q_full;

    coap_enc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .req_type      (req_type),
        .first_option  (first_option),
        .option_number (option_number),
        .value_length  (value_length),
        .value_byte    (value_byte),
        .entry         (enc_entry)
    );

    coap_enc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (enc_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    coap_enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule
`default_nettype wire
